/* rtl/source_text_lexer_defines.svh */
// Assertion macros shared by the lexer RTL.
`ifndef SOURCE_TEXT_LEXER_DEFINES_SVH
`define SOURCE_TEXT_LEXER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/stl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package stl_pkg;

   localparam int OFFSET_BITS   = 16;
   localparam int FIELD_BITS    = 16;
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int COUNT_BITS    = $clog2(FIFO_DEPTH + 1);
   localparam int RSP_BITS      = 2 * FIELD_BITS + 8;
   localparam int RSP_DATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [4:0]             kind_type;

   localparam kind_type KIND_END     = 5'd0;
   localparam kind_type KIND_ILLEGAL = 5'd1;
   localparam kind_type KIND_IDENT   = 5'd2;
   localparam kind_type KIND_INT     = 5'd3;
   localparam kind_type KIND_DEC     = 5'd4;
   localparam kind_type KIND_STRING  = 5'd5;
   localparam kind_type KIND_ASSIGN  = 5'd6;
   localparam kind_type KIND_EQ      = 5'd7;
   localparam kind_type KIND_PLUS    = 5'd8;
   localparam kind_type KIND_MINUS   = 5'd9;
   localparam kind_type KIND_STAR    = 5'd10;
   localparam kind_type KIND_SLASH   = 5'd11;
   localparam kind_type KIND_LT      = 5'd12;
   localparam kind_type KIND_LE      = 5'd13;
   localparam kind_type KIND_GT      = 5'd14;
   localparam kind_type KIND_GE      = 5'd15;
   localparam kind_type KIND_SEMI    = 5'd16;
   localparam kind_type KIND_COMMA   = 5'd17;
   localparam kind_type KIND_LBRACE  = 5'd18;
   localparam kind_type KIND_RBRACE  = 5'd19;
   localparam kind_type KIND_LPAREN  = 5'd20;
   localparam kind_type KIND_RPAREN  = 5'd21;
   localparam kind_type KIND_BANG    = 5'd22;
   localparam kind_type KIND_NE      = 5'd23;
   localparam kind_type KIND_LBRACK  = 5'd24;
   localparam kind_type KIND_RBRACK  = 5'd25;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_BANG   = 8'h21;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_DOT    = 8'h2e;
   localparam logic [7:0] CHAR_LT     = 8'h3c;
   localparam logic [7:0] CHAR_EQUALS = 8'h3d;
   localparam logic [7:0] CHAR_GT     = 8'h3e;
   localparam logic [7:0] CHAR_UNDER  = 8'h5f;

   typedef enum logic [1:0] {
      OPER_ASSIGN = 2'd0,
      OPER_LT     = 2'd1,
      OPER_GT     = 2'd2,
      OPER_BANG   = 2'd3
   } oper_type;

   typedef enum logic [5:0] {
      MODE_IDLE  = 6'b000001,
      MODE_IDENT = 6'b000010,
      MODE_INT   = 6'b000100,
      MODE_DEC   = 6'b001000,
      MODE_STR   = 6'b010000,
      MODE_OPER  = 6'b100000
   } mode_type;

   typedef struct packed {
      kind_type              kind;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] length;
      logic [7:0]            bad;
      logic                  last;
   } token_type;

   function automatic offset_type sat_inc(input offset_type v);
      return (v == '1) ? v : v + offset_type'(1);
   endfunction

   function automatic offset_type span(input offset_type from, input offset_type to);
      return (to >= from) ? to - from : '0;
   endfunction

   function automatic token_type make_token(input kind_type kind, input offset_type start,
                                            input offset_type length, input logic [7:0] bad);
      token_type t;
      t.kind   = kind;
      t.start  = FIELD_BITS'(start);
      t.length = FIELD_BITS'(length);
      t.bad    = bad;
      t.last   = 1'b0;
      return t;
   endfunction

   function automatic kind_type punct_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         8'h2b:   k = KIND_PLUS;
         8'h2d:   k = KIND_MINUS;
         8'h2a:   k = KIND_STAR;
         8'h2f:   k = KIND_SLASH;
         8'h3b:   k = KIND_SEMI;
         8'h2c:   k = KIND_COMMA;
         8'h7b:   k = KIND_LBRACE;
         8'h7d:   k = KIND_RBRACE;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h5b:   k = KIND_LBRACK;
         8'h5d:   k = KIND_RBRACK;
         default: k = KIND_ILLEGAL;
      endcase
      return k;
   endfunction

   function automatic oper_type oper_code(input logic [7:0] c);
      oper_type o;
      case (c)
         CHAR_LT:   o = OPER_LT;
         CHAR_GT:   o = OPER_GT;
         CHAR_BANG: o = OPER_BANG;
         default:   o = OPER_ASSIGN;
      endcase
      return o;
   endfunction

   function automatic kind_type single_kind(input oper_type o);
      kind_type k;
      case (o)
         OPER_LT:   k = KIND_LT;
         OPER_GT:   k = KIND_GT;
         OPER_BANG: k = KIND_BANG;
         default:   k = KIND_ASSIGN;
      endcase
      return k;
   endfunction

   function automatic kind_type double_kind(input oper_type o);
      kind_type k;
      case (o)
         OPER_LT:   k = KIND_LE;
         OPER_GT:   k = KIND_GE;
         OPER_BANG: k = KIND_NE;
         default:   k = KIND_EQ;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

/* rtl/source_text_lexer.sv */
// Streaming lexer. Source bytes enter on the req_ channel, one byte per
// transaction, and a zero byte ends the text. Tokens leave on the rsp_
// channel as kind, start offset, length and offending byte, with rsp_tlast
// set on the final token that a byte produces; one byte yields zero, one or
// two tokens. A byte is taken into an input register, from which the scanner
// classifies it against the open token and writes its tokens into a
// four-entry result queue. A token reaches rsp_ through the input register
// and the queue. One byte is accepted per cycle as long as the queue holds
// at most two tokens, so the byte rate is one per cycle while each byte gives
// at most one token, and is bounded by the rsp_ side at one token per cycle.
// When the receiver stalls, the queue fills and req_tready drops once it can
// no longer take the two tokens a byte may produce; nothing is lost. After a
// zero byte the offset counter restarts at zero for the next text. Reset
// empties the queue and returns the scanner to idle with offset zero.
`timescale 1ns / 1ps
`default_nettype none
`include "source_text_lexer_defines.svh"
module source_text_lexer
   import stl_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [7:0]               req_tdata,   // text_byte
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,   // token_start, token_length,
                                                      // illegal_char
   output kind_type                      rsp_tuser,   // token_kind
   output logic                          rsp_tlast
);

   logic                     hold_ff, hold_in;
   logic [7:0]               byte_ff, byte_in;
   mode_type                 mode_ff, mode_in;
   oper_type                 pend_ff, pend_in;
   offset_type               origin_ff, origin_in;
   offset_type               offset_ff, offset_in;
   token_type                fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;

   logic                     advance;
   logic                     req_take;
   logic                     pop;
   logic                     text_end;
   logic [1:0]               n_tok;
   logic [1:0]               push_n;
   token_type                tok_a, tok_b, idle_tok, head;
   logic                     run_idle, idle_emit;
   logic                     is_letter, is_digit;
   mode_type                 mode_next;
   oper_type                 pend_next;
   offset_type               origin_next;

   assign advance    = hold_ff && (count_ff <= COUNT_BITS'(FIFO_DEPTH - 2));
   assign req_tready = !hold_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign hold_in    = req_take ? 1'b1 : (advance ? 1'b0 : hold_ff);
   assign byte_in    = req_take ? req_tdata : byte_ff;

   assign is_letter = (byte_ff inside {[8'h61:8'h7a], [8'h41:8'h5a], CHAR_UNDER});
   assign is_digit  = (byte_ff inside {[8'h30:8'h39]});

   always_comb begin
      tok_a       = '0;
      tok_b       = '0;
      idle_tok    = '0;
      n_tok       = 2'd0;
      run_idle    = 1'b0;
      idle_emit   = 1'b0;
      mode_next   = mode_ff;
      pend_next   = pend_ff;
      origin_next = origin_ff;

      case (mode_ff)
         MODE_IDENT: begin
            if (!(is_letter || is_digit)) begin
               tok_a    = make_token(KIND_IDENT, origin_ff, span(origin_ff, offset_ff), '0);
               n_tok    = 2'd1;
               run_idle = 1'b1;
            end
         end
         MODE_INT: begin
            if (is_digit) begin
               mode_next = MODE_INT;
            end else if (byte_ff == CHAR_DOT) begin
               mode_next = MODE_DEC;
            end else begin
               tok_a    = make_token(KIND_INT, origin_ff, span(origin_ff, offset_ff), '0);
               n_tok    = 2'd1;
               run_idle = 1'b1;
            end
         end
         MODE_DEC: begin
            if (!is_digit) begin
               tok_a    = make_token(KIND_DEC, origin_ff, span(origin_ff, offset_ff), '0);
               n_tok    = 2'd1;
               run_idle = 1'b1;
            end
         end
         MODE_STR: begin
            if (byte_ff == CHAR_QUOTE) begin
               tok_a     = make_token(KIND_STRING, origin_ff, span(origin_ff, offset_ff), '0);
               n_tok     = 2'd1;
               mode_next = MODE_IDLE;
            end else if (byte_ff == CHAR_NUL) begin
               tok_a    = make_token(KIND_STRING, origin_ff, span(origin_ff, offset_ff), '0);
               n_tok    = 2'd1;
               run_idle = 1'b1;
            end
         end
         MODE_OPER: begin
            if (byte_ff == CHAR_EQUALS) begin
               tok_a     = make_token(double_kind(pend_ff), origin_ff, offset_type'(2), '0);
               n_tok     = 2'd1;
               mode_next = MODE_IDLE;
            end else begin
               tok_a    = make_token(single_kind(pend_ff), origin_ff, offset_type'(1), '0);
               n_tok    = 2'd1;
               run_idle = 1'b1;
            end
         end
         default: begin
            run_idle = 1'b1;
         end
      endcase

      if (run_idle) begin
         mode_next = MODE_IDLE;
         if (byte_ff inside {CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF}) begin
            idle_emit = 1'b0;
         end else if (byte_ff == CHAR_NUL) begin
            idle_emit = 1'b1;
            idle_tok  = make_token(KIND_END, offset_ff, '0, '0);
         end else if (byte_ff inside {CHAR_EQUALS, CHAR_LT, CHAR_GT, CHAR_BANG}) begin
            pend_next   = oper_code(byte_ff);
            mode_next   = MODE_OPER;
            origin_next = offset_ff;
         end else if (byte_ff == CHAR_QUOTE) begin
            mode_next   = MODE_STR;
            origin_next = sat_inc(offset_ff);
         end else if (punct_kind(byte_ff) != KIND_ILLEGAL) begin
            idle_emit = 1'b1;
            idle_tok  = make_token(punct_kind(byte_ff), offset_ff, offset_type'(1), '0);
         end else if (is_letter) begin
            mode_next   = MODE_IDENT;
            origin_next = offset_ff;
         end else if (is_digit) begin
            mode_next   = MODE_INT;
            origin_next = offset_ff;
         end else begin
            idle_emit = 1'b1;
            idle_tok  = make_token(KIND_ILLEGAL, offset_ff, offset_type'(1), byte_ff);
         end
      end

      if (idle_emit) begin
         if (n_tok == 2'd0) begin
            tok_a = idle_tok;
            n_tok = 2'd1;
         end else begin
            tok_b = idle_tok;
            n_tok = 2'd2;
         end
      end

      if (n_tok == 2'd1) begin
         tok_a.last = 1'b1;
      end else if (n_tok == 2'd2) begin
         tok_b.last = 1'b1;
      end

      if (byte_ff == CHAR_NUL) begin
         mode_next = MODE_IDLE;
      end
   end

   assign mode_in   = advance ? mode_next : mode_ff;
   assign pend_in   = advance ? pend_next : pend_ff;
   assign origin_in = advance ? origin_next : origin_ff;
   assign offset_in = !advance ? offset_ff :
                      (byte_ff == CHAR_NUL) ? '0 : sat_inc(offset_ff);
   assign text_end  = advance && (byte_ff == CHAR_NUL);

   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = RSP_DATA_BITS'({head.bad, head.length, head.start});
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign pop        = rsp_tvalid && rsp_tready;
   assign push_n     = advance ? n_tok : 2'd0;
   assign wr_ptr_in  = wr_ptr_ff + FIFO_PTR_BITS'(push_n);
   assign rd_ptr_in  = rd_ptr_ff + FIFO_PTR_BITS'(pop);
   assign count_in   = count_ff + COUNT_BITS'(push_n) - COUNT_BITS'(pop);

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      pend_ff   <= pend_in;
      origin_ff <= origin_in;
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= tok_a;
      end
      if (push_n == 2'd2) begin
         fifo_ff[FIFO_PTR_BITS'(wr_ptr_ff + FIFO_PTR_BITS'(1))] <= tok_b;
      end
      if (reset) begin
         hold_ff   <= 1'b0;
         mode_ff   <= MODE_IDLE;
         offset_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         hold_ff   <= hold_in;
         mode_ff   <= mode_in;
         offset_ff <= offset_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `STL_ASSERT_SAME(a_queue_bound, 1'b1, count_ff <= COUNT_BITS'(FIFO_DEPTH), "queue overflow")
   `STL_ASSERT_SAME(a_end_is_last, rsp_tvalid && (rsp_tuser == KIND_END), rsp_tlast, "end not last")
   `STL_ASSERT_NEXT(a_text_restart, text_end, (offset_ff == '0) && (mode_ff == MODE_IDLE), "no restart")

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import stl_pkg::*;

   localparam int START_LSB      = 0;
   localparam int LENGTH_LSB     = START_LSB + FIELD_BITS;
   localparam int BAD_LSB        = LENGTH_LSB + FIELD_BITS;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_BYTES   = 770;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   kind_type rsp_tuser;
   logic rsp_tlast;

   source_text_lexer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   logic [7:0] text_bytes[$];
   token_type  expected_tokens[$];
   token_type  staged_tokens[$];

   mode_type   scan_state = MODE_IDLE;
   oper_type   held_oper = OPER_ASSIGN;
   offset_type open_start = '0;
   offset_type next_offset = '0;

   int unsigned bytes_taken = 0;
   int unsigned tokens_checked = 0;
   int unsigned texts_ended = 0;
   int unsigned errors = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;
   logic [11:0] rx_cycle = '0;
   int unsigned idle_cycles = 0;

   function automatic bit is_word_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CHAR_UNDER;
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic offset_type length_to(input offset_type p);
      return (p >= open_start) ? p - open_start : '0;
   endfunction

   function automatic kind_type oper_token(input oper_type o, input bit doubled);
      case (o)
         OPER_LT:   return doubled ? KIND_LE : KIND_LT;
         OPER_GT:   return doubled ? KIND_GE : KIND_GT;
         OPER_BANG: return doubled ? KIND_NE : KIND_BANG;
         default:   return doubled ? KIND_EQ : KIND_ASSIGN;
      endcase
   endfunction

   task automatic stage_token(input kind_type k, input offset_type s, input offset_type n,
                              input logic [7:0] bad);
      token_type t;
      t.kind   = k;
      t.start  = FIELD_BITS'(s);
      t.length = FIELD_BITS'(n);
      t.bad    = bad;
      t.last   = 1'b0;
      staged_tokens.push_back(t);
   endtask

   task automatic scan_fresh(input logic [7:0] c, input offset_type p);
      offset_type one;
      one = offset_type'(1);
      scan_state = MODE_IDLE;
      case (c)
         CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF: ;
         CHAR_NUL: stage_token(KIND_END, p, '0, 8'h00);
         CHAR_EQUALS, CHAR_LT, CHAR_GT, CHAR_BANG: begin
            scan_state = MODE_OPER;
            open_start = p;
            held_oper  = (c == CHAR_LT) ? OPER_LT : (c == CHAR_GT) ? OPER_GT :
                         (c == CHAR_BANG) ? OPER_BANG : OPER_ASSIGN;
         end
         CHAR_QUOTE: begin
            scan_state = MODE_STR;
            open_start = (p == '1) ? p : p + one;
         end
         "+": stage_token(KIND_PLUS, p, one, 8'h00);
         "-": stage_token(KIND_MINUS, p, one, 8'h00);
         "*": stage_token(KIND_STAR, p, one, 8'h00);
         "/": stage_token(KIND_SLASH, p, one, 8'h00);
         ";": stage_token(KIND_SEMI, p, one, 8'h00);
         ",": stage_token(KIND_COMMA, p, one, 8'h00);
         "{": stage_token(KIND_LBRACE, p, one, 8'h00);
         "}": stage_token(KIND_RBRACE, p, one, 8'h00);
         "(": stage_token(KIND_LPAREN, p, one, 8'h00);
         ")": stage_token(KIND_RPAREN, p, one, 8'h00);
         "[": stage_token(KIND_LBRACK, p, one, 8'h00);
         "]": stage_token(KIND_RBRACK, p, one, 8'h00);
         default: begin
            if (is_word_char(c)) begin
               scan_state = MODE_IDENT;
               open_start = p;
            end else if (is_digit(c)) begin
               scan_state = MODE_INT;
               open_start = p;
            end else begin
               stage_token(KIND_ILLEGAL, p, one, c);
            end
         end
      endcase
   endtask

   task automatic lex_byte(input logic [7:0] c);
      offset_type p;
      p = next_offset;
      case (scan_state)
         MODE_IDENT: begin
            if (!(is_word_char(c) || is_digit(c))) begin
               stage_token(KIND_IDENT, open_start, length_to(p), 8'h00);
               scan_fresh(c, p);
            end
         end
         MODE_INT, MODE_DEC: begin
            if (is_digit(c)) begin
            end else if (c == CHAR_DOT && scan_state == MODE_INT) begin
               scan_state = MODE_DEC;
            end else begin
               stage_token((scan_state == MODE_DEC) ? KIND_DEC : KIND_INT, open_start,
                           length_to(p), 8'h00);
               scan_fresh(c, p);
            end
         end
         MODE_STR: begin
            if (c == CHAR_QUOTE) begin
               stage_token(KIND_STRING, open_start, length_to(p), 8'h00);
               scan_state = MODE_IDLE;
            end else if (c == CHAR_NUL) begin
               stage_token(KIND_STRING, open_start, length_to(p), 8'h00);
               scan_fresh(c, p);
            end
         end
         MODE_OPER: begin
            if (c == CHAR_EQUALS) begin
               stage_token(oper_token(held_oper, 1'b1), open_start, offset_type'(2), 8'h00);
               scan_state = MODE_IDLE;
            end else begin
               stage_token(oper_token(held_oper, 1'b0), open_start, offset_type'(1), 8'h00);
               scan_fresh(c, p);
            end
         end
         default: scan_fresh(c, p);
      endcase
      if (c == CHAR_NUL) begin
         scan_state  = MODE_IDLE;
         next_offset = '0;
      end else begin
         next_offset = (p == '1) ? p : p + offset_type'(1);
      end
      if (staged_tokens.size() > 0) begin
         staged_tokens[staged_tokens.size() - 1].last = 1'b1;
      end
      while (staged_tokens.size() > 0) begin
         expected_tokens.push_back(staged_tokens.pop_front());
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 40) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         end
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            lex_byte(req_tdata);
            bytes_taken <= bytes_taken + 1;
            if (req_tdata == CHAR_NUL) begin
               texts_ended <= texts_ended + 1;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || text_bytes.size() == 0) begin
               req_tvalid <= 1'b0;
               if (gap_left > 0) begin
                  gap_left <= gap_left - 1;
               end
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= text_bytes.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // Receiver: the stall pattern steps through four modes chosen by rx_cycle[9:8], with one long hold-off.
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1'b1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && bytes_taken >= 400) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_cycle[9:8])
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    rsp_tready <= (rx_cycle[2:0] != 3'd0) && (rx_cycle[4:3] != 2'd2);
            default: rsp_tready <= ($urandom_range(0, 1) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         tokens_checked <= tokens_checked + 1;
         if (expected_tokens.size() == 0) begin
            errors++;
            $display("%0t: token with none expected, actual tuser 0x%0h tdata 0x%0h tlast %0b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
         end else begin
            want = expected_tokens.pop_front();
            compare_field("token_kind", 32'(want.kind), 32'(rsp_tuser));
            compare_field("token_start", 32'(want.start),
                          32'(rsp_tdata[START_LSB +: FIELD_BITS]));
            compare_field("token_length", 32'(want.length),
                          32'(rsp_tdata[LENGTH_LSB +: FIELD_BITS]));
            compare_field("illegal_char", 32'(want.bad), 32'(rsp_tdata[BAD_LSB +: 8]));
            compare_field("tdata padding", 0, 32'(rsp_tdata >> RSP_BITS));
            compare_field("last_of_run", 32'(want.last), 32'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         text_bytes.push_back(s[i]);
      end
   endtask

   function automatic logic [7:0] word_char(input bit allow_digit);
      int unsigned r;
      r = $urandom_range(0, allow_digit ? 62 : 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return CHAR_UNDER;
      return 8'("0" + r - 53);
   endfunction

   initial begin
      string spacing;
      string opers;
      string puncts;
      logic [7:0] c;
      int unsigned pick;
      int unsigned random_start;

      spacing = " \t\r\n";
      opers   = "=<>!";
      puncts  = "+-*/;,{}()[]";

      // Directed: every token kind, operators with and without '=', tokens
      // ended by the next byte, a second point, strings, and ends of text.
      put_text("x_9 = 12.5;\n== <= >= != < > !\t+-*/,{}()[]\r");
      put_text("\"hi\"\"\"Zz(1.2.3 7a");
      text_bytes.push_back(8'h80);
      text_bytes.push_back(8'hff);
      put_text("@#");
      text_bytes.push_back(CHAR_NUL);
      text_bytes.push_back(CHAR_NUL);
      put_text("\"open");
      text_bytes.push_back(CHAR_NUL);
      put_text("abc");
      text_bytes.push_back(CHAR_NUL);
      put_text("<");
      text_bytes.push_back(CHAR_NUL);
      put_text("42");
      text_bytes.push_back(CHAR_NUL);

      random_start = text_bytes.size();
      while (text_bytes.size() - random_start < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            text_bytes.push_back(word_char(1'b0));
            repeat ($urandom_range(0, 7)) text_bytes.push_back(word_char(1'b1));
         end else if (pick < 40) begin
            repeat ($urandom_range(1, 5)) text_bytes.push_back(8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 0) begin
               text_bytes.push_back(CHAR_DOT);
               repeat ($urandom_range(0, 4)) text_bytes.push_back(8'("0" + $urandom_range(0, 9)));
               if ($urandom_range(0, 5) == 0) begin
                  text_bytes.push_back(CHAR_DOT);
               end
            end
         end else if (pick < 50) begin
            text_bytes.push_back(CHAR_QUOTE);
            repeat ($urandom_range(0, 6)) begin
               c = 8'($urandom_range(1, 255));
               text_bytes.push_back((c == CHAR_QUOTE) ? 8'h7e : c);
            end
            if ($urandom_range(0, 7) != 0) begin
               text_bytes.push_back(CHAR_QUOTE);
            end
         end else if (pick < 70) begin
            text_bytes.push_back(opers[$urandom_range(0, 3)]);
            if ($urandom_range(0, 1) == 0) begin
               text_bytes.push_back(CHAR_EQUALS);
            end
         end else if (pick < 85) begin
            text_bytes.push_back(puncts[$urandom_range(0, 11)]);
         end else if (pick < 91) begin
            text_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (pick < 94) begin
            text_bytes.push_back(CHAR_NUL);
         end else begin
            text_bytes.push_back(spacing[$urandom_range(0, 3)]);
         end
         if ($urandom_range(0, 1) == 0) begin
            text_bytes.push_back(spacing[$urandom_range(0, 3)]);
         end
      end
      text_bytes.push_back(CHAR_NUL);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (text_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Lexed %0d bytes in %0d texts and checked %0d tokens,", bytes_taken,
               texts_ended, tokens_checked);
      $display("with bursty input, varied output stalls and a %0d-cycle hold-off.",
               HOLD_CYCLES);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
